@@ hdl/rsv_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the rsa sign and verify block
package rsv_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_CHECK,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_SQR_GO,
		ST_SQR_WAIT,
		ST_DONE
	} state_t;

	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t REG_MODULUS     = 2'd0;
	localparam cfg_idx_t REG_PRIVATE_EXP = 2'd1;
	localparam cfg_idx_t REG_PUBLIC_EXP  = 2'd2;

	localparam logic ACT_SIGN   = 1'b0;
	localparam logic ACT_VERIFY = 1'b1;

	localparam int FIELD_BITS = 16;

endpackage

@@ hdl/rsa_sign_verify.sv @@
`timescale 1ns / 1ps
// rsa sign and verify top level: registers, exponent sequencer, shared multiplier
// sequence: reduce the base with one modular multiply, then one modular multiply per set exponent bit
//   and one square per bit below the top set bit; exponent 0 only reduces the base, n of 0 or 1 goes straight to done
// throughput: one item at a time, next item accepted the cycle after done; the receiver cannot stall
// reset: asynchronous active low, modulus 1, exponents 0, sequencer idle
module rsa_sign_verify #(
	parameter int MODULUS_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [15:0] message,
	input  logic [15:0] signature,
	output logic        done,
	output logic [15:0] value,
	output logic        matches_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int W = MODULUS_BITS;

	rsv_pkg::state_t state_q;
	rsv_pkg::state_t state_d;

	logic [15:0] modulus_q;
	logic [15:0] priv_exp_q;
	logic [15:0] pub_exp_q;

	logic         action_q;
	logic [15:0]  msg_q;
	logic [15:0]  exp_q;
	logic [W-1:0] base_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] n_q;

	logic [W+15:0] mod_ext;
	logic [W+15:0] base_ext;
	logic [W+15:0] acc_ext;
	logic [W-1:0]  n_in;
	logic [W-1:0]  base_in;
	logic          accept;

	logic         mm_start;
	logic [W-1:0] mm_a;
	logic [W-1:0] mm_b;
	logic [W-1:0] mm_prod;
	logic         mm_done;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	assign mod_ext  = {{W{1'b0}}, modulus_q};
	assign base_ext = {{W{1'b0}}, (action == rsv_pkg::ACT_VERIFY) ? signature : message};
	assign acc_ext  = {16'b0, acc_q};
	assign n_in     = mod_ext[W-1:0];
	assign base_in  = base_ext[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= 16'd1;
			priv_exp_q <= 16'd0;
			pub_exp_q  <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rsv_pkg::REG_MODULUS:     modulus_q  <= cfg_data;
				rsv_pkg::REG_PRIVATE_EXP: priv_exp_q <= cfg_data;
				rsv_pkg::REG_PUBLIC_EXP:  pub_exp_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rsv_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (n_in <= W'(1)) ? rsv_pkg::ST_DONE : rsv_pkg::ST_RED_GO;
				end
			end
			rsv_pkg::ST_RED_GO:   state_d = rsv_pkg::ST_RED_WAIT;
			rsv_pkg::ST_RED_WAIT: if (mm_done) state_d = rsv_pkg::ST_CHECK;
			rsv_pkg::ST_CHECK: begin
				if (exp_q == 16'd0) begin
					state_d = rsv_pkg::ST_DONE;
				end else if (exp_q[0]) begin
					state_d = rsv_pkg::ST_MUL_GO;
				end else begin
					state_d = rsv_pkg::ST_SQR_GO;
				end
			end
			rsv_pkg::ST_MUL_GO:   state_d = rsv_pkg::ST_MUL_WAIT;
			rsv_pkg::ST_MUL_WAIT: if (mm_done) state_d = rsv_pkg::ST_CHECK;
			rsv_pkg::ST_SQR_GO:   state_d = rsv_pkg::ST_SQR_WAIT;
			rsv_pkg::ST_SQR_WAIT: if (mm_done) state_d = rsv_pkg::ST_CHECK;
			rsv_pkg::ST_DONE:     state_d = rsv_pkg::ST_IDLE;
			default:              state_d = rsv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mm_start = 1'b0;
		mm_a     = acc_q;
		mm_b     = base_q;
		busy     = 1'b1;
		done     = 1'b0;
		case (state_q)
			rsv_pkg::ST_IDLE: busy = 1'b0;
			rsv_pkg::ST_RED_GO: begin
				mm_start = 1'b1;
				mm_a     = W'(1);
			end
			rsv_pkg::ST_MUL_GO: mm_start = 1'b1;
			rsv_pkg::ST_SQR_GO: begin
				mm_start = 1'b1;
				mm_a     = base_q;
			end
			rsv_pkg::ST_DONE: done = 1'b1;
			default: ;
		endcase
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			rsv_pkg::ST_IDLE: begin
				if (accept) begin
					action_q <= action;
					msg_q    <= message;
					exp_q    <= (action == rsv_pkg::ACT_VERIFY) ? pub_exp_q : priv_exp_q;
					base_q   <= base_in;
					n_q      <= n_in;
					acc_q    <= '0;
				end
			end
			rsv_pkg::ST_RED_WAIT: begin
				if (mm_done) begin
					base_q <= mm_prod;
					acc_q  <= W'(1);
				end
			end
			rsv_pkg::ST_MUL_WAIT: begin
				if (mm_done) begin
					acc_q    <= mm_prod;
					exp_q[0] <= 1'b0;
				end
			end
			rsv_pkg::ST_SQR_WAIT: begin
				if (mm_done) begin
					base_q <= mm_prod;
					exp_q  <= {1'b0, exp_q[15:1]};
				end
			end
			default: ;
		endcase
	end

	assign value       = acc_ext[15:0];
	assign matches_res = (action_q == rsv_pkg::ACT_VERIFY) && (acc_ext[15:0] == msg_q);

	rsv_modmul #(
		.W(W)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.n      (n_q),
		.prod   (mm_prod),
		.done   (mm_done)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("item accepted but block not busy");
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");
	a_sign_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		done && (action_q == rsv_pkg::ACT_SIGN) |-> !matches_res)
		else $error("match flag set on sign");
	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done && (n_q > W'(1)) |-> (acc_q < n_q))
		else $error("result not below modulus");
	a_mm_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == rsv_pkg::ST_RED_WAIT || state_q == rsv_pkg::ST_MUL_WAIT
			|| state_q == rsv_pkg::ST_SQR_WAIT))
		else $error("multiplier finished outside a wait state");
`endif

endmodule

@@ hdl/rsv_modmul.sv @@
`timescale 1ns / 1ps
// shift-add modular multiplier, one bit of b per cycle
module rsv_modmul #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] n,
	output logic [W-1:0] prod,
	output logic         done
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  r_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  n_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [W:0] dbl;
	logic [W:0] dbl_red;
	logic [W:0] sum;
	logic [W:0] sum_red;

	// r <- (2r + bit*a) mod n, with r and a below n
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, n_q}) ? (dbl - {1'b0, n_q}) : dbl;
		sum     = dbl_red + (b_q[W-1] ? {1'b0, a_q} : {(W+1){1'b0}});
		sum_red = (sum >= {1'b0, n_q}) ? (sum - {1'b0, n_q}) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= a;
			b_q <= b;
			n_q <= n;
		end else if (run_q) begin
			r_q <= sum_red[W-1:0];
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign prod = r_q;
	assign done = done_q;

`ifndef SYNTHESIS
	a_run_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> run_q)
		else $error("multiplier did not start");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !run_q)
		else $error("multiplier done while running");
	a_prod_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (r_q < n_q))
		else $error("product not reduced");
`endif

endmodule
